>>> src/srgb_gamma_encoder_assert.svh
// Assertion macros for the sRGB gamma encoder.
// Needs no other file. Simulation gets the checks; synthesis sees empty macros.
`ifndef SRGB_GAMMA_ENCODER_ASSERT_SVH
`define SRGB_GAMMA_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SGE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgenc: same-cycle check failed");
// Next-cycle implication check.
`define SGE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgenc: next-cycle check failed");
`else
`define SGE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SGE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sgenc_pkg.sv
// Shared types, constants and constant functions of the sRGB gamma encoder.
// Depends on nothing; every module of the encoder imports it.
`default_nettype none

package sgenc_pkg;

	// Fraction bits of the log2 result and number of exp2 root steps.
	localparam int LOG_FRAC  = 24;
	localparam int EXP_STEPS = 30;

	// Exponent 1/2.4 in Q30 for the sRGB curve.
	localparam logic [30:0] P_SRGB_Q30 = 31'd447392427;

	// Reset value of the power-law exponent, Q16.
	localparam logic [16:0] GAMMA_RESET = 17'd29789;

	// Constant divisor used by the sRGB scaling divider.
	localparam int SRGB_DIVISOR = 1000;

	// Register indexes of the configuration port.
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_GAMMA = 1'b1;

	// Encoding modes.
	localparam logic MODE_SRGB = 1'b0;

	typedef struct packed {
		logic        mode;
		logic [16:0] inv_gamma;
	} cfg_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic lin;
	} lane_flags_t;

	// Floor square root of a 64-bit value, bit by bit.
	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bv;
		n   = n_in;
		res = '0;
		bv  = 64'h4000_0000_0000_0000;
		while (bv > n) bv = bv >> 2;
		while (bv != 64'd0) begin
			if (n >= res + bv) begin
				n   = n - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q30 as a chain of floor square roots starting at 2.0.
	function automatic logic [31:0] root_q30(input int k);
		logic [63:0] r;
		int j;
		r = 64'd1 << 31;
		for (j = 1; j <= k; j++) r = isqrt64(r << 30);
		return r[31:0];
	endfunction

endpackage

`default_nettype wire

>>> src/sgenc_log2.sv
// Fraction part of log2 by repeated squaring, one squaring per pipeline stage.
// Depends on sgenc_pkg. A tag of side data travels alongside each stage.
`default_nettype none

module sgenc_log2 import sgenc_pkg::*; #(
	parameter int TAG_W = 8
) (
	input  logic                clk,
	input  logic                en,
	input  logic [30:0]         z_in,
	input  logic [TAG_W-1:0]    tag_in,
	output logic [LOG_FRAC-1:0] frac_out,
	output logic [TAG_W-1:0]    tag_out
);

	logic [30:0]         z_q   [1:LOG_FRAC];
	logic [LOG_FRAC-1:0] f_q   [1:LOG_FRAC];
	logic [TAG_W-1:0]    tag_q [1:LOG_FRAC];

	for (genvar g = 1; g <= LOG_FRAC; g++) begin : g_step
		logic [30:0]         z_prev;
		logic [LOG_FRAC-1:0] f_prev;
		logic [TAG_W-1:0]    t_prev;
		logic [61:0]         sq;
		logic [31:0]         sqs;

		if (g == 1) begin : g_first
			assign z_prev = z_in;
			assign f_prev = '0;
			assign t_prev = tag_in;
		end else begin : g_next
			assign z_prev = z_q[g-1];
			assign f_prev = f_q[g-1];
			assign t_prev = tag_q[g-1];
		end

		// Square in Q30; a result of 2.0 or more yields a one bit and a halving.
		assign sq  = 62'(z_prev) * 62'(z_prev);
		assign sqs = sq[61:30];

		always_ff @(posedge clk) begin
			if (en) begin
				z_q[g]   <= sqs[31] ? sqs[31:1] : sqs[30:0];
				f_q[g]   <= {f_prev[LOG_FRAC-2:0], sqs[31]};
				tag_q[g] <= t_prev;
			end
		end
	end

	assign frac_out = f_q[LOG_FRAC];
	assign tag_out  = tag_q[LOG_FRAC];

endmodule

`default_nettype wire

>>> src/sgenc_exp2.sv
// 2^f in Q30 as a product of root factors, one factor per pipeline stage.
// Depends on sgenc_pkg for the root constants.
`default_nettype none

module sgenc_exp2 import sgenc_pkg::*; #(
	parameter int TAG_W = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [EXP_STEPS-1:0] fr_in,
	input  logic [TAG_W-1:0]     tag_in,
	output logic [31:0]          acc_out,
	output logic [TAG_W-1:0]     tag_out
);

	logic [31:0]          acc_q [1:EXP_STEPS];
	logic [EXP_STEPS-1:0] fr_q  [1:EXP_STEPS];
	logic [TAG_W-1:0]     tag_q [1:EXP_STEPS];

	for (genvar g = 1; g <= EXP_STEPS; g++) begin : g_step
		localparam logic [31:0] ROOT = root_q30(g);
		logic [31:0]          acc_prev;
		logic [EXP_STEPS-1:0] fr_prev;
		logic [TAG_W-1:0]     t_prev;
		logic [63:0]          rnd;

		if (g == 1) begin : g_first
			assign acc_prev = 32'd1 << 30;
			assign fr_prev  = fr_in;
			assign t_prev   = tag_in;
		end else begin : g_next
			assign acc_prev = acc_q[g-1];
			assign fr_prev  = fr_q[g-1];
			assign t_prev   = tag_q[g-1];
		end

		// Multiply by this stage's root and round back to Q30.
		assign rnd = 64'(acc_prev) * 64'(ROOT) + (64'd1 << 29);

		always_ff @(posedge clk) begin
			if (en) begin
				acc_q[g] <= fr_prev[EXP_STEPS-g] ? rnd[61:30] : acc_prev;
				fr_q[g]  <= fr_prev;
				tag_q[g] <= t_prev;
			end
		end
	end

	assign acc_out = acc_q[EXP_STEPS];
	assign tag_out = tag_q[EXP_STEPS];

endmodule

`default_nettype wire

>>> src/sgenc_div.sv
// Division by the constant SRGB_DIVISOR through a reciprocal multiply, one stage.
// Depends on sgenc_pkg. The dividend must stay below SRGB_DIVISOR * 2^QB.
`default_nettype none

module sgenc_div import sgenc_pkg::*; #(
	parameter int QB    = 20,
	parameter int RW    = 30,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RW-1:0]    dvd_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic [QB-1:0]    quo_out,
	output logic [TAG_W-1:0] tag_out
);

	// The divisor lies between 512 and 1024, so a reciprocal rounded up with
	// RW + 10 fraction bits gives the exact floor for every RW-bit dividend.
	localparam int SH = RW + 10;
	localparam int MW = SH - 9;
	localparam int PW = RW + MW;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(SRGB_DIVISOR - 1)) / 64'(SRGB_DIVISOR);

	logic [PW-1:0]    prod;
	logic [QB-1:0]    quo_q;
	logic [TAG_W-1:0] tag_q;

	// Multiply by the reciprocal and keep the integer part.
	assign prod = PW'(dvd_in) * PW'(RECIP[MW-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= prod[SH+QB-1:SH];
			tag_q <= tag_in;
		end
	end

	assign quo_out = quo_q;
	assign tag_out = tag_q;

endmodule

`default_nettype wire

>>> src/sgenc_lane.sv
// One color channel of the encoder: sign split, log2, power, exp2, scaling.
// Depends on sgenc_pkg, sgenc_log2, sgenc_exp2 and sgenc_div.
`default_nettype none

module sgenc_lane import sgenc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 3
) (
	input  logic                             clk,
	input  logic                             en,
	input  cfg_t                             cfg,
	input  logic [INT_BITS+FRAC_BITS:0]      raw_in,
	output logic [INT_BITS+FRAC_BITS:0]      res_out
);

	localparam int W      = 1 + INT_BITS + FRAC_BITS;
	localparam int EW     = $clog2(W);
	localparam int AW     = W + 15;
	localparam int RW     = W + 10;
	localparam int SCL    = 30 - FRAC_BITS;
	localparam int TAG1_W = 3 + 8 + AW;
	localparam int TAG2_W = 5 + W;
	localparam logic [63:0] LIN_MAX  = (64'd31308 << FRAC_BITS) / 64'd10000000;
	localparam logic [63:0] SUB55    = 64'd55 << 30;
	localparam logic [63:0] HALFD    = 64'd500 << SCL;
	localparam logic [63:0] DIV_LIM  = 64'(SRGB_DIVISOR) << W;
	localparam logic [63:0] Y_CLAMP  = 64'd1 << 50;
	localparam logic [W-1:0] CAP_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] CAP_NEG = {1'b1, {(W-1){1'b0}}};

	// Stage 1: magnitude, normalization and the sRGB linear dividend.
	logic [W-1:0]    mag;
	logic [EW-1:0]   e_msb;
	logic [W+29:0]   zsh;
	lane_flags_t     flags_d;
	logic [AW-1:0]   alin_d;
	logic [7:0]      ex_d;

	always_comb begin
		mag   = raw_in[W-1] ? (~raw_in + W'(1)) : raw_in;
		e_msb = '0;
		for (int i = 0; i < W; i++) begin
			if (mag[i]) e_msb = EW'(i);
		end
		zsh          = {mag, 30'b0} >> e_msb;
		flags_d.neg  = raw_in[W-1];
		flags_d.zero = (mag == '0);
		flags_d.lin  = (64'(mag) <= LIN_MAX);
		alin_d       = AW'(mag) * AW'(12920) + AW'(500);
		ex_d         = 8'(e_msb) - 8'(FRAC_BITS);
	end

	logic [30:0]       z_s1;
	logic [TAG1_W-1:0] tag_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= zsh[30:0];
			tag_s1 <= {flags_d, ex_d, alin_d};
		end
	end

	// Log2 fraction.
	logic [LOG_FRAC-1:0] frac_l;
	logic [TAG1_W-1:0]   tag_l;

	sgenc_log2 #(.TAG_W(TAG1_W)) u_log2 (
		.clk      (clk),
		.en       (en),
		.z_in     (z_s1),
		.tag_in   (tag_s1),
		.frac_out (frac_l),
		.tag_out  (tag_l)
	);

	// Stage 2: full log2 value, its magnitude and the low partial product.
	lane_flags_t        flags_l;
	logic signed [7:0]  ex_l;
	logic [AW-1:0]      alin_l;
	logic signed [31:0] lval;
	logic [29:0]        lmag;
	logic [30:0]        pexp;

	always_comb begin
		{flags_l, ex_l, alin_l} = tag_l;
		lval = $signed({ex_l, 24'b0}) + $signed({8'b0, frac_l});
		lmag = lval[31] ? 30'(-lval) : lval[29:0];
		pexp = (cfg.mode == MODE_SRGB) ? P_SRGB_Q30 : {cfg.inv_gamma, 14'b0};
	end

	logic [29:0]   lmag_s2;
	logic          lneg_s2;
	logic [45:0]   plo_s2;
	logic [14:0]   phi_s2;
	lane_flags_t   flags_s2;
	logic [AW-1:0] alin_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lmag_s2  <= lmag;
			lneg_s2  <= lval[31];
			plo_s2   <= 46'(lmag) * 46'(pexp[15:0]);
			phi_s2   <= pexp[30:16];
			flags_s2 <= flags_l;
			alin_s2  <= alin_l;
		end
	end

	// Stage 3: high partial product and the signed exponent product.
	logic [44:0] phi_prod;
	logic [60:0] tmag;

	always_comb begin
		phi_prod = 45'(lmag_s2) * 45'(phi_s2);
		tmag     = {phi_prod, 16'b0} + 61'(plo_s2);
	end

	logic signed [61:0] t_s3;
	lane_flags_t        flags_s3;
	logic [AW-1:0]      alin_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3     <= lneg_s2 ? -$signed(62'(tmag)) : $signed(62'(tmag));
			flags_s3 <= flags_s2;
			alin_s3  <= alin_s2;
		end
	end

	// Exp2 of the fraction; the integer part rides in the tag.
	logic [31:0]       acc_e;
	logic [TAG1_W-1:0] tag_e;

	sgenc_exp2 #(.TAG_W(TAG1_W)) u_exp2 (
		.clk     (clk),
		.en      (en),
		.fr_in   (t_s3[53:24]),
		.tag_in  ({flags_s3, t_s3[61:54], alin_s3}),
		.acc_out (acc_e),
		.tag_out (tag_e)
	);

	// Stage 4: scale by 2^n with rounding and saturation.
	lane_flags_t        flags_e;
	logic signed [7:0]  n_e;
	logic [AW-1:0]      alin_e;
	logic [7:0]         negn;
	logic [5:0]         sh;
	logic [63:0]        y_d;

	always_comb begin
		{flags_e, n_e, alin_e} = tag_e;
		negn = 8'(-n_e);
		sh   = negn[5:0];
		if (n_e >= 8'sd31) begin
			y_d = 64'd1 << 62;
		end else if (n_e >= 8'sd0) begin
			y_d = 64'(acc_e) << n_e[4:0];
		end else if (n_e <= -8'sd33) begin
			y_d = '0;
		end else begin
			y_d = (64'(acc_e) + (64'd1 << (sh - 6'd1))) >> sh;
		end
	end

	logic [63:0]   y_s4;
	lane_flags_t   flags_s4;
	logic [AW-1:0] alin_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s4     <= y_d;
			flags_s4 <= flags_e;
			alin_s4  <= alin_e;
		end
	end

	// Stage 5: sRGB offset and scaling into a dividend, power-law rounding.
	logic [50:0] yc;
	logic [63:0] num;
	logic [63:0] num2;
	logic [63:0] apow;
	logic [63:0] dvd;
	logic [63:0] rg;
	logic [W-1:0] rgc;

	always_comb begin
		yc   = (y_s4 > Y_CLAMP) ? Y_CLAMP[50:0] : y_s4[50:0];
		num  = 64'(yc) * 64'd1055;
		num2 = (num > SUB55) ? (num - SUB55) : '0;
		apow = (num2 + HALFD) >> SCL;
		dvd  = flags_s4.lin ? 64'(alin_s4) : apow;
		rg   = (y_s4 + (64'd1 << (SCL - 1))) >> SCL;
		rgc  = (rg >= (64'd1 << W)) ? {W{1'b1}} : rg[W-1:0];
	end

	logic [RW-1:0]     dvd_s5;
	logic [TAG2_W-1:0] tag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s5 <= dvd[RW-1:0];
			tag_s5 <= {flags_s4, (dvd >= DIV_LIM), (cfg.mode == MODE_SRGB), rgc};
		end
	end

	// Division by the sRGB scale constant.
	logic [W-1:0]      quo;
	logic [TAG2_W-1:0] tag_d;

	sgenc_div #(.QB(W), .RW(RW), .TAG_W(TAG2_W)) u_div (
		.clk     (clk),
		.en      (en),
		.dvd_in  (dvd_s5),
		.tag_in  (tag_s5),
		.quo_out (quo),
		.tag_out (tag_d)
	);

	// Result selection, saturation and sign restore.
	lane_flags_t  flags_f;
	logic         ovf_f;
	logic         use_div_f;
	logic [W-1:0] rg_f;
	logic [W-1:0] r;
	logic [W-1:0] cap;

	always_comb begin
		{flags_f, ovf_f, use_div_f, rg_f} = tag_d;
		r   = use_div_f ? (ovf_f ? {W{1'b1}} : quo) : rg_f;
		cap = flags_f.neg ? CAP_NEG : CAP_POS;
		if (r > cap) r = cap;
		if (flags_f.zero) begin
			res_out = '0;
		end else begin
			res_out = flags_f.neg ? (~r + W'(1)) : r;
		end
	end

endmodule

`default_nettype wire

>>> src/srgb_gamma_encoder.sv
// sRGB / power-law gamma encoder: three channel lanes and an output register.
// Throughput is one RGB triple per cycle while no output beat is held; each lane is
// a fully pipelined chain of 24 log2 squaring stages, 30 exp2 root stages and a
// one-stage divide. A stalled output beat holds the whole pipeline. Reset clears
// the valid chain, the output valid and the configuration registers (sRGB mode,
// exponent 29789).
`default_nettype none

module srgb_gamma_encoder import sgenc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [INT_BITS+FRAC_BITS:0] red_linear,
	input  logic signed [INT_BITS+FRAC_BITS:0] green_linear,
	input  logic signed [INT_BITS+FRAC_BITS:0] blue_linear,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [INT_BITS+FRAC_BITS:0] red_encoded,
	output logic signed [INT_BITS+FRAC_BITS:0] green_encoded,
	output logic signed [INT_BITS+FRAC_BITS:0] blue_encoded
);

`include "srgb_gamma_encoder_assert.svh"

	localparam int W        = 1 + INT_BITS + FRAC_BITS;
	localparam int LANE_LAT = 5 + LOG_FRAC + EXP_STEPS + 1;

	// Configuration registers.
	cfg_t cfg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_SRGB;
			cfg_q.inv_gamma <= GAMMA_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MODE:  cfg_q.mode      <= pwdata[0];
				REG_GAMMA: cfg_q.inv_gamma <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:  prdata = {31'b0, cfg_q.mode};
			REG_GAMMA: prdata = {15'b0, cfg_q.inv_gamma};
			default:   prdata = '0;
		endcase
	end

	// Pipeline advance: everything moves unless a finished beat is held.
	logic out_valid_q;
	logic en;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	logic [LANE_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LANE_LAT-2:0], in_valid};
			out_valid_q <= vld_q[LANE_LAT-1];
		end
	end

	// Channel lanes.
	logic [W-1:0] red_res;
	logic [W-1:0] green_res;
	logic [W-1:0] blue_res;

	sgenc_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_red (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.raw_in  (red_linear),
		.res_out (red_res)
	);

	sgenc_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_green (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.raw_in  (green_linear),
		.res_out (green_res)
	);

	sgenc_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_blue (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.raw_in  (blue_linear),
		.res_out (blue_res)
	);

	// Merge the three lanes into one output beat.
	logic [W-1:0] red_q;
	logic [W-1:0] green_q;
	logic [W-1:0] blue_q;

	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= red_res;
			green_q <= green_res;
			blue_q  <= blue_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_encoded   = red_q;
	assign green_encoded = green_q;
	assign blue_encoded  = blue_q;

	// An accepted beat enters the first stage.
	`SGE_ASSERT_NXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, vld_q[0])
	// A held output beat freezes the valid chain.
	`SGE_ASSERT_NXT(a_hold_freezes, clk, arst_n, out_valid_q && out_stall, $stable(vld_q))
	// With the last stage empty, a moving pipeline leaves no output beat.
	`SGE_ASSERT_NXT(a_no_phantom, clk, arst_n, en && !vld_q[LANE_LAT-1], !out_valid_q)

endmodule

`default_nettype wire

>>> verif/srgb_gamma_encoder_checker.sv
// Checker for the sRGB gamma encoder: tracks register writes, predicts each output beat.
// Depends on the encoder's port list only; instantiated beside the block by the bench top.
`timescale 1ns / 1ps

module srgb_gamma_encoder_checker #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               pready,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [INT_BITS+FRAC_BITS:0] red_linear,
	input  logic signed [INT_BITS+FRAC_BITS:0] green_linear,
	input  logic signed [INT_BITS+FRAC_BITS:0] blue_linear,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [INT_BITS+FRAC_BITS:0] red_encoded,
	input  logic signed [INT_BITS+FRAC_BITS:0] green_encoded,
	input  logic signed [INT_BITS+FRAC_BITS:0] blue_encoded,
	output int                                 pending,
	output int                                 fail_count
);

	localparam int W = 1 + INT_BITS + FRAC_BITS;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned SRGB_EXP_Q30 = 64'd447392427;
	localparam logic [2:0] ADDR_MODE  = 3'd0;
	localparam logic [2:0] ADDR_GAMMA = 3'd4;

	typedef logic [W-1:0] chan_t;
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	logic            mode_q;
	logic [16:0]     gamma_q;
	pixel_t          encoded_queue[$];
	longint unsigned half_roots[0:30];

	assign pending = encoded_queue.size();

	// Integer floor square root.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned acc, b;
		acc = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= acc + b) begin
				v = v - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return acc;
	endfunction

	// Successive square roots of two, the factors of the exp2 product.
	initial begin
		half_roots[0] = ONE_Q30 << 1;
		for (int k = 1; k <= 30; k++) half_roots[k] = floor_sqrt(half_roots[k-1] << 30);
	end

	// log2 of the magnitude in real units, Q24, by repeated squaring.
	function automatic longint log2_fixed(longint unsigned m);
		longint e;
		longint unsigned z, frac;
		e = 0;
		frac = 0;
		for (int i = 0; i < 64; i++) if (m[i]) e = i;
		z = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
		for (int i = 0; i < 24; i++) begin
			z = (z * z) >> 30;
			if (z >= (ONE_Q30 << 1)) begin
				z = z >> 1;
				frac = frac | (64'd1 << (23 - i));
			end
		end
		return (e - FRAC_BITS) * (64'sd1 << 24) + longint'(frac);
	endfunction

	// Magnitude raised to an exponent given in Q30; result in Q30.
	function automatic longint unsigned power_q30(longint unsigned m, longint unsigned p);
		longint t;
		longint unsigned u, fr, acc;
		int n;
		t = log2_fixed(m) * longint'(p);
		u = longint'(t + (64'sd1 << 62));
		n = int'(u >> 54) - 256;
		fr = (u >> 24) & (ONE_Q30 - 1);
		acc = ONE_Q30;
		for (int k = 1; k <= 30; k++)
			if (fr[30-k]) acc = (acc * half_roots[k] + (ONE_Q30 >> 1)) >> 30;
		if (n >= 0) begin
			if (n >= 31) return 64'd1 << 62;
			return acc << n;
		end
		if (-n >= 33) return 0;
		return (acc + (64'd1 << (-n - 1))) >> (-n);
	endfunction

	// Encode one signed channel: strip the sign, encode, restore it.
	function automatic chan_t encode_chan(chan_t raw);
		longint unsigned m, r, y, num, d, cap;
		logic neg;
		neg = raw[W-1];
		m = neg ? ((64'd1 << W) - raw) : raw;
		if (m == 0) return '0;
		if (mode_q == 1'b0) begin
			if (m * 10000000 <= (64'd31308 << FRAC_BITS)) begin
				r = (m * 1292 + 50) / 100;
			end else begin
				y = power_q30(m, SRGB_EXP_Q30);
				d = 64'd1000 << (30 - FRAC_BITS);
				if (y > (64'd1 << 50)) y = 64'd1 << 50;
				num = y * 1055;
				num = (num > 55 * ONE_Q30) ? num - 55 * ONE_Q30 : 0;
				r = (num + d / 2) / d;
			end
		end else begin
			y = power_q30(m, longint'(gamma_q) << 14);
			r = (y + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		end
		cap = neg ? (64'd1 << (W - 1)) : ((64'd1 << (W - 1)) - 1);
		if (r > cap) r = cap;
		return neg ? chan_t'((64'd1 << W) - r) : chan_t'(r);
	endfunction

	// Register writes, predictions on input beats, comparisons on output beats.
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			mode_q <= 1'b0;
			gamma_q <= 17'd29789;
			encoded_queue.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_MODE) mode_q <= pwdata[0];
				else if (paddr == ADDR_GAMMA) gamma_q <= pwdata[16:0];
			end
			if (in_valid && !in_stall) begin
				got = {encode_chan(red_linear), encode_chan(green_linear),
					encode_chan(blue_linear)};
				encoded_queue = {encoded_queue, got};
			end
			if (out_valid && !out_stall) begin
				if (encoded_queue.size() == 0) begin
					$error("output beat with no pixel outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = encoded_queue.pop_front();
					if (red_encoded !== want.red || green_encoded !== want.green ||
							blue_encoded !== want.blue) begin
						if (red_encoded !== want.red)
							$error("red_encoded expected %0h got %0h", want.red, red_encoded);
						if (green_encoded !== want.green)
							$error("green_encoded expected %0h got %0h", want.green,
								green_encoded);
						if (blue_encoded !== want.blue)
							$error("blue_encoded expected %0h got %0h", want.blue, blue_encoded);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> verif/srgb_gamma_encoder_tb.sv
// Bench top for the sRGB gamma encoder: clock, reset, register writes and pixel stimulus.
// Depends on srgb_gamma_encoder and srgb_gamma_encoder_checker.
`timescale 1ns / 1ps

module srgb_gamma_encoder_tb;

	localparam int W = 20;
	localparam logic [2:0] ADDR_MODE  = 3'd0;
	localparam logic [2:0] ADDR_GAMMA = 3'd4;
	localparam logic SRGB_CURVE  = 1'b0;
	localparam logic POWER_CURVE = 1'b1;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [W-1:0] red_linear, green_linear, blue_linear;
	logic signed [W-1:0] red_encoded, green_encoded, blue_encoded;
	int pending, fail_count;
	int tx_idle_pct, rx_idle_pct, quiet_cycles, beats_sent;
	logic hold_req;

	srgb_gamma_encoder i_dut (.*);

	srgb_gamma_encoder_checker i_checker (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAIL srgb_gamma_encoder");
			$finish;
		end
	end

	// Register write: setup cycle then access cycle, only once the pipeline is empty.
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one pixel beat, with random gaps ahead of it, until it is taken.
	task automatic send_pixel(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red_linear <= r;
		green_linear <= g;
		blue_linear <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats_sent++;
		// Idling profile follows progress through the run.
		if (beats_sent < 550) begin
			tx_idle_pct = 34;
			rx_idle_pct = 84;
		end else if (beats_sent < 1100) begin
			tx_idle_pct = 84;
			rx_idle_pct = 34;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// Random channel value, weighted toward the interesting magnitudes.
	function automatic logic [W-1:0] rand_chan();
		logic [W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = W'($urandom_range(0, (1 << W) - 1));
			1: v = W'($urandom_range(0, 400));
			default: v = W'($urandom_range(0, 65536 * 2));
		endcase
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	// Edge values of a channel, including both sides of the linear segment limit.
	task automatic send_directed();
		logic [W-1:0] edges[12];
		edges = '{20'd0, 20'd1, -20'sd1, 20'h7ffff, 20'h80000, 20'd205, 20'd206,
			-20'sd206, 20'd65536, -20'sd65536, 20'h55555, 20'haaaaa};
		for (int i = 0; i < 12; i++)
			send_pixel(edges[i], edges[(i + 4) % 12], edges[(i + 8) % 12]);
	endtask

	// Settings walked through in turn: curve select and exponent.
	initial begin
		logic        modes[7];
		logic [16:0] gammas[7];
		modes  = '{SRGB_CURVE, POWER_CURVE, POWER_CURVE, POWER_CURVE, POWER_CURVE,
			POWER_CURVE, SRGB_CURVE};
		gammas = '{17'd29789, 17'd29789, 17'd6554, 17'd65536, 17'd0, 17'h1ffff, 17'd40000};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		red_linear = '0;
		green_linear = '0;
		blue_linear = '0;
		hold_req = 1'b0;
		beats_sent = 0;
		tx_idle_pct = 34;
		rx_idle_pct = 84;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int s = 0; s < 7; s++) begin
			if (s > 0) begin
				write_reg(ADDR_MODE, {31'd0, modes[s]});
				write_reg(ADDR_GAMMA, {15'd0, gammas[s]});
			end
			send_directed();
			if (s == 5) hold_req = 1'b1;
			for (int i = 0; i < 225; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
		end
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) $display("PASS srgb_gamma_encoder");
		else $display("FAIL srgb_gamma_encoder");
		$finish;
	end

endmodule
